[hdl/fir_lp_pkg.sv]
// Shared types, constants and the coefficient table of the 201-tap low-pass FIR.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fir_lp_pkg;

   localparam int TAPS         = 201;
   localparam int HIST_DEPTH   = TAPS - 1;
   localparam int HALF_COEFS   = 101;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 18;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + $clog2(TAPS);
   localparam int TAP_WIDTH    = $clog2(TAPS);
   localparam int ADDR_WIDTH   = $clog2(HIST_DEPTH);
   localparam int FRAC_SHIFT   = COEF_WIDTH - 1;
   localparam int SHIFT_WIDTH  = ACC_WIDTH + 1 - FRAC_SHIFT;
   localparam int LEN_WIDTH    = 16;

   localparam logic signed [COEF_WIDTH-1:0] COEF_HALF [0:HALF_COEFS-1] = '{
      18'sd0, -18'sd8, -18'sd17, -18'sd24, -18'sd31, -18'sd36, -18'sd39, -18'sd40,
      -18'sd39, -18'sd35, -18'sd28, -18'sd19, -18'sd7, 18'sd7, 18'sd22, 18'sd38,
      18'sd52, 18'sd66, 18'sd76, 18'sd82, 18'sd83, 18'sd79, 18'sd68, 18'sd51,
      18'sd28, 18'sd0, -18'sd32, -18'sd65, -18'sd98, -18'sd128, -18'sd153, -18'sd170,
      -18'sd177, -18'sd173, -18'sd155, -18'sd125, -18'sd83, -18'sd30, 18'sd31, 18'sd97,
      18'sd163, 18'sd225, 18'sd278, 18'sd317, 18'sd338, 18'sd338, 18'sd315, 18'sd268,
      18'sd198, 18'sd107, 18'sd0, -18'sd118, -18'sd239, -18'sd355, -18'sd459,
      -18'sd541, -18'sd594, -18'sd611, -18'sd589, -18'sd525, -18'sd419, -18'sd275,
      -18'sd98, 18'sd102, 18'sd315, 18'sd526, 18'sd721, 18'sd887, 18'sd1009,
      18'sd1075, 18'sd1074, 18'sd1000, 18'sd851, 18'sd630, 18'sd342, 18'sd0,
      -18'sd379, -18'sd775, -18'sd1163, -18'sd1518, -18'sd1813, -18'sd2021,
      -18'sd2118, -18'sd2082, -18'sd1898, -18'sd1556, -18'sd1051, -18'sd388,
      18'sd422, 18'sd1361, 18'sd2402, 18'sd3513, 18'sd4659, 18'sd5800, 18'sd6896,
      18'sd7905, 18'sd8791, 18'sd9518, 18'sd10059, 18'sd10392, 18'sd10505
   };

   // The taps are symmetric, so only the first half is stored.
   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_WIDTH-1:0] j);
      logic [TAP_WIDTH-1:0] k;
      k = (j < TAP_WIDTH'(HALF_COEFS)) ? j : TAP_WIDTH'(TAPS - 1) - j;
      return COEF_HALF[k[$clog2(HALF_COEFS)-1:0]];
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH,
      ST_HOLD
   } fir_lp_state_type;

   typedef struct packed {
      logic                 load;
      logic                 issue;
      logic [TAP_WIDTH-1:0] tap;
      logic                 write;
      logic                 out_load;
      logic                 out_pass;
   } fir_lp_cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } fir_lp_status_type;

endpackage

[hdl/fir_lp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the sample history of the filter.
`timescale 1ns / 1ps

module fir_lp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 200
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fir_lp_dp.sv]
// Datapath of the FIR: history RAM, circular pointers, one shared MAC, rounding
// and the output register. Depends on fir_lp_pkg and fir_lp_ram.
`timescale 1ns / 1ps

module fir_lp_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fir_lp_pkg::fir_lp_cmd_type              cmd,
   output fir_lp_pkg::fir_lp_status_type           status,
   input  logic signed [fir_lp_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fir_lp_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   output logic                                    rsp_passed_through
);
   import fir_lp_pkg::*;

   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(HIST_DEPTH - 1);
   localparam logic signed [SHIFT_WIDTH-1:0] SAT_HI =
      SHIFT_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SHIFT_WIDTH-1:0] SAT_LO =
      SHIFT_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic [ADDR_WIDTH-1:0]          wp_ff, wp_in;
   logic [ADDR_WIDTH-1:0]          rd_ptr_ff, rd_ptr_in;
   logic signed [COEF_WIDTH-1:0]   coef_ff, coef_in;
   logic                           tap0_ff, tap0_in;
   logic                           v1_ff, v1_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic                           v2_ff, v2_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_pass_ff, rsp_pass_in;

   logic                           ram_rd_en;
   logic [SAMPLE_WIDTH-1:0]        ram_rd_data;
   logic signed [SAMPLE_WIDTH-1:0] operand;
   logic signed [ACC_WIDTH:0]      biased;
   logic signed [SHIFT_WIDTH-1:0]  shifted;
   logic signed [SAMPLE_WIDTH-1:0] rounded;

   fir_lp_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_en = cmd.issue && (cmd.tap != '0);
   assign operand   = tap0_ff ? x_ff : $signed(ram_rd_data);

   // Round half up at the Q0.17 point, then clamp to the sample range.
   always_comb begin
      biased  = (ACC_WIDTH+1)'(acc_ff) + ((ACC_WIDTH+1)'(1) <<< (FRAC_SHIFT - 1));
      shifted = biased[ACC_WIDTH:FRAC_SHIFT];
      if (shifted > SAT_HI) begin
         rounded = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         rounded = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         rounded = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      x_in          = x_ff;
      wp_in         = wp_ff;
      rd_ptr_in     = rd_ptr_ff;
      coef_in       = coef_ff;
      tap0_in       = tap0_ff;
      v1_in         = cmd.issue;
      prod_in       = prod_ff;
      v2_in         = v1_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_pass_in   = rsp_pass_ff;

      if (cmd.load) begin
         x_in      = req_sample;
         acc_in    = '0;
         rd_ptr_in = (wp_ff == '0) ? LAST_ADDR : wp_ff - 1'b1;
      end
      if (cmd.issue) begin
         coef_in = coef_at(cmd.tap);
         tap0_in = (cmd.tap == '0);
         if (ram_rd_en) begin
            rd_ptr_in = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - 1'b1;
         end
      end
      if (v1_ff) begin
         prod_in = coef_ff * operand;
      end
      if (v2_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
      if (cmd.write) begin
         wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = cmd.out_pass ? x_ff : rounded;
         rsp_pass_in   = cmd.out_pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      rd_ptr_ff     <= rd_ptr_in;
      coef_ff       <= coef_in;
      tap0_ff       <= tap0_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_pass_ff   <= rsp_pass_in;
   end

   assign status.busy     = v1_ff || v2_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_passed_through  = rsp_pass_ff;

endmodule

[hdl/fir_lp_ctrl.sv]
// Controller of the FIR: record tracking (warm-up count, short-record flag)
// and the sequencer that steps the shared MAC over the taps. Uses fir_lp_pkg.
`timescale 1ns / 1ps

module fir_lp_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_first_of_record,
   input  logic [fir_lp_pkg::LEN_WIDTH-1:0]      req_record_length,
   output fir_lp_pkg::fir_lp_cmd_type            cmd,
   input  fir_lp_pkg::fir_lp_status_type         status
);
   import fir_lp_pkg::*;

   localparam logic [TAP_WIDTH-1:0] LAST_TAP  = TAP_WIDTH'(TAPS - 1);
   localparam logic [TAP_WIDTH-1:0] WARM_FULL = TAP_WIDTH'(HIST_DEPTH);

   fir_lp_state_type     state_ff, state_in;
   logic [TAP_WIDTH-1:0] tap_ff, tap_in;
   logic [TAP_WIDTH-1:0] warm_ff, warm_in;
   logic                 short_ff, short_in;
   logic                 emit_ff, emit_in;
   logic                 pass_ff, pass_in;

   logic [TAP_WIDTH-1:0] warm_eff;
   logic                 short_eff;

   always_comb begin
      warm_eff  = req_first_of_record ? '0 : warm_ff;
      short_eff = req_first_of_record ?
                  (req_record_length < LEN_WIDTH'(TAPS)) : short_ff;
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      warm_in   = warm_ff;
      short_in  = short_ff;
      emit_in   = emit_ff;
      pass_in   = pass_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.tap   = tap_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               short_in = short_eff;
               emit_in  = !short_eff;
               pass_in  = (warm_eff < WARM_FULL);
               warm_in  = (warm_eff < WARM_FULL) ? warm_eff + 1'b1 : warm_eff;
               tap_in   = '0;
               if (!short_eff && !(warm_eff < WARM_FULL)) begin
                  state_in = ST_MAC;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            tap_in    = tap_ff + 1'b1;
            if (tap_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The current word enters the history only after every tap is read.
            cmd.write = 1'b1;
            state_in  = emit_ff ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_pass = pass_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         warm_ff  <= '0;
         short_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         warm_ff  <= warm_in;
         short_ff <= short_in;
      end
      tap_ff  <= tap_in;
      emit_ff <= emit_in;
      pass_ff <= pass_in;
   end

endmodule

[hdl/fir_lp_checker.sv]
// Port-level checks for the FIR core, attached to the top level by bind.
// Depends on fir_lowpass_201_tap_core.
`timescale 1ns / 1ps

module fir_lp_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_filtered_sample,
   input logic        rsp_passed_through
);

   // A stalled result word stays in place unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered_sample)
                                    && $stable(rsp_passed_through)))
      else $error("stalled result word changed");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // One word is worked on at a time: an accepted word makes the core busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while busy");

endmodule

bind fir_lowpass_201_tap_core fir_lp_props u_fir_lp_props (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_filtered_sample (rsp_filtered_sample),
   .rsp_passed_through  (rsp_passed_through)
);

[hdl/fir_lowpass_201_tap_core.sv]
// Top level of the 201-tap low-pass FIR over sample records.
// Depends on fir_lp_pkg, fir_lp_ctrl and fir_lp_dp.
//
// Input channel req_*: one signed 16-bit sample per word. The first word of a
// record has req_first_of_record set and carries req_record_length. A record
// shorter than 201 samples produces no result words. Otherwise the first 200
// samples come back unchanged with rsp_passed_through set, and every later
// sample returns the rounded, saturated sum of 201 coefficient products.
// A word is taken when valid is high and stall is low on its channel.
// Order: a warm-up word is written into the history and then placed on rsp_*;
// a filtered word is formed by the single shared multiply-accumulate unit
// stepping through 201 taps plus its 2-stage pipeline, then the input word is
// written into the history and the result is placed on rsp_*. One word is
// processed at a time, so a new word is taken only once the last one is done.
// A short-record word is only written into the history, never returned.
// Reset clears the record state, the history pointer and the output register.
// When the receiver stalls, the finished word waits in the output register
// while the next input word is already being taken and processed.
`timescale 1ns / 1ps

module fir_lowpass_201_tap_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [fir_lp_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                      req_first_of_record,
   input  logic [fir_lp_pkg::LEN_WIDTH-1:0]          req_record_length,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [fir_lp_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   output logic                                      rsp_passed_through
);
   import fir_lp_pkg::*;

   fir_lp_cmd_type    cmd;
   fir_lp_status_type status;

   fir_lp_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_of_record (req_first_of_record),
      .req_record_length   (req_record_length),
      .cmd                 (cmd),
      .status              (status)
   );

   fir_lp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_passed_through  (rsp_passed_through)
   );

endmodule
